// ===== sv/hsfd_pkg.sv =====
`timescale 1ns / 1ps

package hsfd_pkg;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    localparam logic [17:0] T_SPAN   = 18'd175000;
    localparam logic [17:0] H_SPAN   = 18'd125000;
    localparam logic [18:0] T_OFFSET = 19'd45000;
    localparam logic [18:0] H_OFFSET = 19'd6000;
    localparam logic [16:0] FULL_SCALE = 17'd65535;

    // one completed frame handed from front to back
    typedef struct packed {
        logic [15:0] temp_raw;
        logic [15:0] hum_raw;
        logic        good;
    } frame_t;

    // partial quotient of x / 65535 with x = q0 * 65536 + low
    typedef struct packed {
        logic [17:0] q0;
        logic [18:0] r0;
    } divpart_t;

    function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (v[7])
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            else
                v = {v[6:0], 1'b0};
        end
        return v;
    endfunction

    // first fold: x mod 65535 == (x[15:0] + x[33:16]) mod 65535
    function automatic divpart_t div_fold(input logic [33:0] p);
        divpart_t d;
        d.q0 = p[33:16];
        d.r0 = {3'b000, p[15:0]} + {1'b0, p[33:16]};
        return d;
    endfunction

    // second fold plus one correction, then offset
    function automatic logic [17:0] div_finish(input divpart_t d, input logic [18:0] offset);
        logic [2:0]  q1;
        logic [16:0] r1;
        logic        c;
        logic [18:0] q;
        q1 = d.r0[18:16];
        r1 = {1'b0, d.r0[15:0]} + {14'd0, q1};
        c  = (r1 >= FULL_SCALE);
        q  = {1'b0, d.q0} + {16'd0, q1} + {18'd0, c};
        return 18'(q - offset);
    endfunction

endpackage

// ===== sv/hsfd_front.sv =====
`timescale 1ns / 1ps

module hsfd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          rx_byte,
    input  logic                frame_first,
    input  logic                accept,
    output logic                push,
    output hsfd_pkg::frame_t    frame
);

    localparam logic [2:0] POS_T_HI  = 3'd0;
    localparam logic [2:0] POS_T_LO  = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_HI  = 3'd3;
    localparam logic [2:0] POS_H_LO  = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] t_raw_reg, t_raw_next;
    logic        t_good_reg, t_good_next;
    logic [15:0] h_raw_reg, h_raw_next;
    logic [2:0]  pos_eff;

    always_comb
    begin
        pos_eff = (frame_first || pos_reg > POS_H_CRC) ? POS_T_HI : pos_reg;
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        t_raw_next  = t_raw_reg;
        t_good_next = t_good_reg;
        h_raw_next  = h_raw_reg;
        push        = 1'b0;
        if (accept)
        begin
            unique case (pos_eff)
                POS_T_HI:
                begin
                    crc_next   = hsfd_pkg::crc_feed(hsfd_pkg::CRC_INIT, rx_byte);
                    t_raw_next = {rx_byte, 8'h00};
                    pos_next   = POS_T_LO;
                end
                POS_T_LO:
                begin
                    crc_next   = hsfd_pkg::crc_feed(crc_reg, rx_byte);
                    t_raw_next = {t_raw_reg[15:8], rx_byte};
                    pos_next   = POS_T_CRC;
                end
                POS_T_CRC:
                begin
                    t_good_next = (rx_byte == crc_reg);
                    crc_next    = hsfd_pkg::CRC_INIT;
                    pos_next    = POS_H_HI;
                end
                POS_H_HI:
                begin
                    crc_next   = hsfd_pkg::crc_feed(hsfd_pkg::CRC_INIT, rx_byte);
                    h_raw_next = {rx_byte, 8'h00};
                    pos_next   = POS_H_LO;
                end
                POS_H_LO:
                begin
                    crc_next   = hsfd_pkg::crc_feed(crc_reg, rx_byte);
                    h_raw_next = {h_raw_reg[15:8], rx_byte};
                    pos_next   = POS_H_CRC;
                end
                default:
                begin
                    crc_next = hsfd_pkg::CRC_INIT;
                    pos_next = POS_T_HI;
                    push     = 1'b1;
                end
            endcase
        end
        frame.temp_raw = t_raw_reg;
        frame.hum_raw  = h_raw_reg;
        frame.good     = t_good_reg && (rx_byte == crc_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= POS_T_HI;
            crc_reg    <= hsfd_pkg::CRC_INIT;
            t_raw_reg  <= 16'd0;
            t_good_reg <= 1'b0;
            h_raw_reg  <= 16'd0;
        end
        else
        begin
            pos_reg    <= pos_next;
            crc_reg    <= crc_next;
            t_raw_reg  <= t_raw_next;
            t_good_reg <= t_good_next;
            h_raw_reg  <= h_raw_next;
        end
    end

endmodule

// ===== sv/hsfd_queue.sv =====
`timescale 1ns / 1ps

module hsfd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  hsfd_pkg::frame_t    push_data,
    input  logic                pop,
    output logic                full,
    output logic                not_empty,
    output hsfd_pkg::frame_t    pop_data
);

    hsfd_pkg::frame_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    always_comb
    begin
        full        = (count_reg == 2'd2);
        not_empty   = (count_reg != 2'd0);
        do_push     = push && !full;
        do_pop      = pop && not_empty;
        pop_data    = entry_reg[rd_ptr_reg];
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/hsfd_back.sv =====
`timescale 1ns / 1ps

module hsfd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                frame_valid,
    input  hsfd_pkg::frame_t    frame,
    output logic                frame_pop,
    output logic                res_valid,
    input  logic                res_ready,
    output logic signed [17:0]  temperature_milli,
    output logic signed [17:0]  humidity_milli,
    output logic                status
);

    logic en;

    logic                s1_valid_reg;
    logic [33:0]         s1_t_prod_reg, s1_h_prod_reg;
    logic                s1_good_reg;

    logic                s2_valid_reg;
    hsfd_pkg::divpart_t  s2_t_reg, s2_h_reg;
    logic                s2_good_reg;

    logic                out_valid_reg;
    logic [17:0]         out_t_reg, out_h_reg;
    logic                out_status_reg;

    // whole pipe moves together whenever the output slot can take a value
    assign en        = !out_valid_reg || res_ready;
    assign frame_pop = en && frame_valid;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_t_prod_reg <= 34'(frame.temp_raw) * 34'(hsfd_pkg::T_SPAN);
            s1_h_prod_reg <= 34'(frame.hum_raw) * 34'(hsfd_pkg::H_SPAN);
            s1_good_reg   <= frame.good;
            s2_t_reg      <= hsfd_pkg::div_fold(s1_t_prod_reg);
            s2_h_reg      <= hsfd_pkg::div_fold(s1_h_prod_reg);
            s2_good_reg   <= s1_good_reg;
            out_t_reg     <= s2_good_reg ? hsfd_pkg::div_finish(s2_t_reg, hsfd_pkg::T_OFFSET)
                                         : 18'd0;
            out_h_reg     <= s2_good_reg ? hsfd_pkg::div_finish(s2_h_reg, hsfd_pkg::H_OFFSET)
                                         : 18'd0;
            out_status_reg <= !s2_good_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= frame_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    assign res_valid         = out_valid_reg;
    assign temperature_milli = signed'(out_t_reg);
    assign humidity_milli    = signed'(out_h_reg);
    assign status            = out_status_reg;

endmodule

// ===== sv/humidity_sensor_frame_decoder.sv =====
`timescale 1ns / 1ps

// Decodes the six-byte response of a temperature/humidity sensor.
// Input channel: rx_byte with frame_first, handshake rx_valid / rx_ready. One request
// per byte in bus order: temperature word, its CRC-8, humidity word, its CRC-8.
// frame_first high restarts the frame at that byte.
// Output channel: temperature_milli, humidity_milli, status, handshake
// res_valid / res_ready. One result per completed frame; status 1 means a CRC-8
// (poly 0x31, init 0xFF) mismatch in either word, and both values then read zero.
// Throughput: one byte per cycle while rx_ready is high. The front checks CRC in
// the cycle it takes a byte and pushes the finished frame into a two-entry queue.
// Pipeline: from the queue a frame passes a multiplier stage, a first reciprocal
// fold stage for the divide by 65535, and a second fold into the output register.
// When the receiver stalls, the back pipe holds; the queue absorbs up to two more
// frames, and rx_ready drops once it is full until the back pipe moves again.
// Reset: frame position returns to the first byte, running CRC to 0xFF, queue and
// pipeline empty, res_valid low.
module humidity_sensor_frame_decoder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rx_valid,
    output logic                rx_ready,
    input  logic [7:0]          rx_byte,
    input  logic                frame_first,
    output logic                res_valid,
    input  logic                res_ready,
    output logic signed [17:0]  temperature_milli,
    output logic signed [17:0]  humidity_milli,
    output logic                status
);

    logic             accept;
    logic             push;
    logic             full;
    logic             not_empty;
    logic             pop;
    hsfd_pkg::frame_t push_frame;
    hsfd_pkg::frame_t pop_frame;

    assign rx_ready = !full;
    assign accept   = rx_valid && rx_ready;

    hsfd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_byte     (rx_byte),
        .frame_first (frame_first),
        .accept      (accept),
        .push        (push),
        .frame       (push_frame)
    );

    hsfd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_frame),
        .pop       (pop),
        .full      (full),
        .not_empty (not_empty),
        .pop_data  (pop_frame)
    );

    hsfd_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .frame_valid       (not_empty),
        .frame             (pop_frame),
        .frame_pop         (pop),
        .res_valid         (res_valid),
        .res_ready         (res_ready),
        .temperature_milli (temperature_milli),
        .humidity_milli    (humidity_milli),
        .status            (status)
    );

endmodule

// ===== sim/hsfd_reading_monitor.sv =====
`timescale 1ns / 1ps

package hsfd_tb_pkg;

    localparam logic [7:0] CRC8_POLY = 8'h31;
    localparam logic [7:0] CRC8_SEED = 8'hFF;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_CRC_FAIL = 1'b1;

    // where the next byte lands within a six-byte response
    typedef enum logic [2:0]
    {
        SLOT_T_HI,
        SLOT_T_LO,
        SLOT_T_CRC,
        SLOT_H_HI,
        SLOT_H_LO,
        SLOT_H_CRC
    } slot_e;

    typedef struct
    {
        logic signed [17:0] temp_milli;
        logic signed [17:0] hum_milli;
        logic               status;
    } reading_t;

    // lfsr form, one message bit at a time, msb first
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        logic       fb;
        r = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = r[7] ^ b[i];
            r  = {r[6:0], 1'b0};
            if (fb)
                r = r ^ CRC8_POLY;
        end
        return r;
    endfunction

    function automatic logic [7:0] crc8_of_word(input logic [15:0] w);
        return crc8_step(crc8_step(CRC8_SEED, w[15:8]), w[7:0]);
    endfunction

endpackage

module hsfd_reading_monitor
    import hsfd_tb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rx_valid,
    input  logic               rx_ready,
    input  logic [7:0]         rx_byte,
    input  logic               frame_first,
    input  logic               res_valid,
    input  logic               res_ready,
    input  logic signed [17:0] temperature_milli,
    input  logic signed [17:0] humidity_milli,
    input  logic               status,
    output int                 mismatch_count,
    output int                 outstanding,
    output int                 frames_checked,
    output int                 crc_failures,
    output int                 resyncs
);

    localparam longint FULL_SCALE  = 65535;
    localparam longint TEMP_SPAN   = 175000;
    localparam longint TEMP_OFFSET = 45000;
    localparam longint HUM_SPAN    = 125000;
    localparam longint HUM_OFFSET  = 6000;

    slot_e       slot;
    slot_e       cur;
    logic [7:0]  crc;
    logic [15:0] temp_raw;
    logic [15:0] hum_raw;
    logic        temp_good;
    logic        good;
    reading_t    want;
    reading_t    pending_readings[$];

    function automatic logic signed [17:0] to_milli(input logic [15:0] raw, input longint span,
                                                    input longint offset);
        longint v;
        v = (longint'(raw) * span) / FULL_SCALE - offset;
        return v[17:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot           = SLOT_T_HI;
            crc            = CRC8_SEED;
            temp_raw       = '0;
            hum_raw        = '0;
            temp_good      = 1'b0;
            pending_readings.delete();
            mismatch_count = 0;
            outstanding    = 0;
            frames_checked = 0;
            crc_failures   = 0;
            resyncs        = 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (pending_readings.size() == 0)
                begin
                    $error("result with no frame pending: temperature_milli %0d humidity_milli %0d status %0b",
                           temperature_milli, humidity_milli, status);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_readings.pop_front();
                    if (temperature_milli !== want.temp_milli)
                    begin
                        $error("temperature_milli: expected %0d, actual %0d",
                               want.temp_milli, temperature_milli);
                        mismatch_count++;
                    end
                    if (humidity_milli !== want.hum_milli)
                    begin
                        $error("humidity_milli: expected %0d, actual %0d",
                               want.hum_milli, humidity_milli);
                        mismatch_count++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status: expected %0b, actual %0b", want.status, status);
                        mismatch_count++;
                    end
                end
            end

            if (rx_valid && rx_ready)
            begin
                cur = (frame_first || slot > SLOT_H_CRC) ? SLOT_T_HI : slot;
                if (frame_first && slot != SLOT_T_HI)
                    resyncs++;
                case (cur)
                    SLOT_T_HI:
                    begin
                        crc      = crc8_step(CRC8_SEED, rx_byte);
                        temp_raw = {rx_byte, 8'h00};
                        slot     = SLOT_T_LO;
                    end
                    SLOT_T_LO:
                    begin
                        crc           = crc8_step(crc, rx_byte);
                        temp_raw[7:0] = rx_byte;
                        slot          = SLOT_T_CRC;
                    end
                    SLOT_T_CRC:
                    begin
                        temp_good = (rx_byte == crc);
                        crc       = CRC8_SEED;
                        slot      = SLOT_H_HI;
                    end
                    SLOT_H_HI:
                    begin
                        crc     = crc8_step(CRC8_SEED, rx_byte);
                        hum_raw = {rx_byte, 8'h00};
                        slot    = SLOT_H_LO;
                    end
                    SLOT_H_LO:
                    begin
                        crc          = crc8_step(crc, rx_byte);
                        hum_raw[7:0] = rx_byte;
                        slot         = SLOT_H_CRC;
                    end
                    default:
                    begin
                        // both words must pass, otherwise values read zero
                        good = temp_good && (rx_byte == crc);
                        want.temp_milli = good ? to_milli(temp_raw, TEMP_SPAN, TEMP_OFFSET) : '0;
                        want.hum_milli  = good ? to_milli(hum_raw, HUM_SPAN, HUM_OFFSET) : '0;
                        want.status     = good ? STATUS_OK : STATUS_CRC_FAIL;
                        pending_readings.push_back(want);
                        frames_checked++;
                        if (!good)
                            crc_failures++;
                        crc  = CRC8_SEED;
                        slot = SLOT_T_HI;
                    end
                endcase
            end

            outstanding = pending_readings.size();
        end
    end

endmodule

// ===== sim/tb_humidity_sensor_frame_decoder.sv =====
`timescale 1ns / 1ps

module tb_humidity_sensor_frame_decoder;

    import hsfd_tb_pkg::*;

    localparam int RANDOM_BYTES    = 700;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int BURST_FRAMES    = 8;
    localparam int SETTLE_CYCLES   = 20;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               rx_valid    = 1'b0;
    logic               rx_ready;
    logic [7:0]         rx_byte     = 8'h00;
    logic               frame_first = 1'b0;
    logic               res_valid;
    logic               res_ready   = 1'b0;
    logic signed [17:0] temperature_milli;
    logic signed [17:0] humidity_milli;
    logic               status;

    int mismatch_count;
    int outstanding;
    int frames_checked;
    int crc_failures;
    int resyncs;

    int bytes_sent     = 0;
    int stall_requests = 0;
    bit stall_active   = 1'b0;
    bit gaps_off       = 1'b0;

    always #5 clk = ~clk;

    humidity_sensor_frame_decoder u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .rx_valid          (rx_valid),
        .rx_ready          (rx_ready),
        .rx_byte           (rx_byte),
        .frame_first       (frame_first),
        .res_valid         (res_valid),
        .res_ready         (res_ready),
        .temperature_milli (temperature_milli),
        .humidity_milli    (humidity_milli),
        .status            (status)
    );

    hsfd_reading_monitor u_reading_monitor (
        .clk               (clk),
        .rst_n             (rst_n),
        .rx_valid          (rx_valid),
        .rx_ready          (rx_ready),
        .rx_byte           (rx_byte),
        .frame_first       (frame_first),
        .res_valid         (res_valid),
        .res_ready         (res_ready),
        .temperature_milli (temperature_milli),
        .humidity_milli    (humidity_milli),
        .status            (status),
        .mismatch_count    (mismatch_count),
        .outstanding       (outstanding),
        .frames_checked    (frames_checked),
        .crc_failures      (crc_failures),
        .resyncs           (resyncs)
    );

    function automatic int pick_gap();
        int r;
        if (gaps_off)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [15:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'h0000;
        if (r == 1)
            return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    // one request, then a random pause with valid low, possibly none
    task automatic put_byte(input logic [7:0] b, input logic first);
        int gap;
        @(negedge clk);
        rx_valid    <= 1'b1;
        rx_byte     <= b;
        frame_first <= first;
        do
            @(posedge clk);
        while (!rx_ready);
        bytes_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            rx_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // n_bytes below six leaves a truncated frame behind
    task automatic send_frame(input logic [15:0] t_word, input logic [15:0] h_word,
                              input logic first, input logic bad_t, input logic bad_h,
                              input int n_bytes);
        logic [7:0] frame_bytes[6];
        frame_bytes[0] = t_word[15:8];
        frame_bytes[1] = t_word[7:0];
        frame_bytes[2] = crc8_of_word(t_word) ^ (bad_t ? 8'($urandom_range(1, 255)) : 8'h00);
        frame_bytes[3] = h_word[15:8];
        frame_bytes[4] = h_word[7:0];
        frame_bytes[5] = crc8_of_word(h_word) ^ (bad_h ? 8'($urandom_range(1, 255)) : 8'h00);
        for (int i = 0; i < n_bytes; i++)
            put_byte(frame_bytes[i], (i == 0) ? first : 1'b0);
    endtask

    // result side
    initial
    begin
        int hold;
        int r;
        int stalls_served;
        stalls_served = 0;
        forever
        begin
            @(negedge clk);
            if (stalls_served < stall_requests)
            begin
                stalls_served++;
                stall_active = 1'b1;
                res_ready <= 1'b0;
                hold = HOLD_OFF_CYCLES;
            end
            else
            begin
                stall_active = 1'b0;
                r = $urandom_range(0, 99);
                if (r < 60)
                begin
                    res_ready <= 1'b1;
                    hold = $urandom_range(1, 12);
                end
                else if (r < 65)
                begin
                    res_ready <= 1'b1;
                    hold = $urandom_range(40, 120);
                end
                else if (r < 95)
                begin
                    res_ready <= 1'b0;
                    hold = $urandom_range(1, 3);
                end
                else
                begin
                    res_ready <= 1'b0;
                    hold = $urandom_range(15, 40);
                end
            end
            repeat (hold - 1) @(negedge clk);
        end
    end

    initial
    begin
        int start_count;
        int frame_no;
        int kind;
        int n;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // flag low on the very first byte, extremes of both words
        send_frame(16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b0, 6);
        send_frame(16'hFFFF, 16'h0000, 1'b1, 1'b0, 1'b0, 6);
        // temperature word corrupt, flag low after a finished frame
        send_frame(16'h8000, 16'h7FFF, 1'b0, 1'b1, 1'b0, 6);
        // partial frame dropped by a resync, then humidity word corrupt
        put_byte(8'hA5, 1'b1);
        put_byte(8'h5A, 1'b0);
        send_frame(16'h1234, 16'hFFFF, 1'b1, 1'b0, 1'b1, 6);

        start_count = bytes_sent;
        frame_no    = 0;
        while (bytes_sent - start_count < RANDOM_BYTES)
        begin
            frame_no++;
            gaps_off = ($urandom_range(0, 7) == 0);
            if (frame_no == 25)
            begin
                // back-to-back frames while results are held off
                @(negedge clk);
                rx_valid <= 1'b0;
                stall_requests++;
                wait (stall_active);
                gaps_off = 1'b1;
                repeat (BURST_FRAMES)
                    send_frame(pick_word(), pick_word(), 1'b1, 1'b0, 1'b0, 6);
                gaps_off = 1'b0;
            end
            else if (frame_no % 40 == 0)
            begin
                @(negedge clk);
                rx_valid <= 1'b0;
                wait (outstanding == 0);
            end
            kind = $urandom_range(0, 99);
            if (kind < 70)
                send_frame(pick_word(), pick_word(), $urandom_range(0, 3) != 0,
                           $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0, 6);
            else if (kind < 85)
                send_frame(pick_word(), pick_word(), 1'b1, 1'b0, 1'b0, $urandom_range(1, 5));
            else
            begin
                n = $urandom_range(1, 8);
                repeat (n)
                    put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
        end

        @(negedge clk);
        rx_valid <= 1'b0;
        wait (outstanding == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("sent %0d bytes: %0d frames decoded, %0d with bad crc, %0d resyncs,",
                 bytes_sent, frames_checked, crc_failures, resyncs);
        $display("with result back-pressure filling the decoder and a full drain pause");
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
